@@ sv/smbf_pkg.sv @@
// constants and types shared by the socks message boundary finder
package smbf_pkg;
    localparam int LENGTH_BITS  = 16;
    localparam int USERID_LIMIT = 255;
    localparam int DOMAIN_LIMIT = 253;

    localparam logic [1:0] VERDICT_SEARCH = 2'd0;
    localparam logic [1:0] VERDICT_FLUSH  = 2'd1;
    localparam logic [1:0] VERDICT_STOP   = 2'd2;

    localparam logic [3:0] ST_INIT      = 4'd0;
    localparam logic [3:0] ST_V5_NEG    = 4'd1;
    localparam logic [3:0] ST_V4_RESP   = 4'd2;
    localparam logic [3:0] ST_USERPASS  = 4'd3;
    localparam logic [3:0] ST_V5_REQ    = 4'd4;
    localparam logic [3:0] ST_V5_RESP   = 4'd5;
    localparam logic [3:0] ST_BR_NEG    = 4'd6;
    localparam logic [3:0] ST_BR_AUTH   = 4'd7;
    localparam logic [3:0] ST_BR_REQ    = 4'd8;
    localparam logic [3:0] ST_BR_RESP   = 4'd9;
    localparam logic [3:0] ST_ESTAB     = 4'd10;
    localparam logic [3:0] ST_ERROR     = 4'd11;

    localparam logic [1:0] PHASE_USERID = 2'd0;
    localparam logic [1:0] PHASE_DOMAIN = 2'd1;
    localparam logic [1:0] PHASE_DONE   = 2'd2;

    typedef logic [LENGTH_BITS-1:0] len_t;
    typedef logic [7:0] byte_t;
endpackage

@@ sv/socks_message_boundary_finder.sv @@
// socks4/socks5 message boundary finder, one byte per cycle while s_ready is high
// the verdict word for a buffer is registered when its last word is taken
// throughput: one word per cycle while s_ready is high; scan state updates as each word is taken,
// and the verdict is computed from the updated state into the output register
// reset: aresetn synchronous active low clears scan state, latched session
// and the output valid
module socks_message_boundary_finder import smbf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_buffer_start,
    input  logic       s_buffer_end,
    input  logic       s_from_client,
    input  logic [3:0] s_session_state,
    input  logic       s_handoff_done,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_verdict,
    output logic [15:0] m_flush_length,
    output logic       m_length_saturated
);
    localparam len_t CNT_MAX = {LENGTH_BITS{1'b1}};

    len_t       cnt_reg, cnt_next;
    byte_t      hdr_reg [8];
    byte_t      hdr_next [8];
    logic [5:0] sess_reg, sess_next;
    logic [9:0] up_end_reg, up_end_next;
    logic [1:0] phase_reg, phase_next;
    len_t       uid_end_reg, uid_end_next;
    len_t       dom_end_reg, dom_end_next;
    logic       too_long_reg, too_long_next;
    logic       over_reg, over_next;

    logic       m_valid_reg;
    logic [1:0] verdict_reg, verdict_next;
    logic [15:0] flen_reg, flen_next;
    logic       sat_reg;
    logic       take;

    // output register frees whenever it is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_verdict = verdict_reg;
    assign m_flush_length = flen_reg;
    assign m_length_saturated = sat_reg;

    // scan state update for one word
    always_comb begin
        len_t  i;
        byte_t b;
        logic  v4a;
        logic  clr;
        len_t  i1;
        i  = '0;
        b  = s_data_byte;
        clr = s_buffer_start;
        for (int k = 0; k < 8; k++) hdr_next[k] = clr ? 8'h00 : hdr_reg[k];
        cnt_next      = clr ? '0 : cnt_reg;
        up_end_next   = clr ? '0 : up_end_reg;
        phase_next    = clr ? PHASE_USERID : phase_reg;
        uid_end_next  = clr ? '0 : uid_end_reg;
        dom_end_next  = clr ? '0 : dom_end_reg;
        too_long_next = clr ? 1'b0 : too_long_reg;
        over_next     = clr ? 1'b0 : over_reg;
        sess_next     = clr ? {s_handoff_done, s_from_client, s_session_state} : sess_reg;
        i  = cnt_next;
        i1 = i + len_t'(1);
        if (i < len_t'(8)) hdr_next[i[2:0]] = b;
        if (i >= len_t'(2) && {1'b0, i} == (LENGTH_BITS+1)'(hdr_next[1]) + (LENGTH_BITS+1)'(2))
            up_end_next = 10'd3 + 10'(hdr_next[1]) + 10'(b);
        v4a = hdr_next[4] == 8'h00 && hdr_next[5] == 8'h00 &&
              hdr_next[6] == 8'h00 && hdr_next[7] != 8'h00;
        if (i >= len_t'(8) && !too_long_next) begin
            if (phase_next == PHASE_USERID) begin
                if (b == 8'h00) begin
                    uid_end_next = i1;
                    if (v4a) begin
                        phase_next = PHASE_DOMAIN;
                    end else begin
                        dom_end_next = i1;
                        phase_next = PHASE_DONE;
                    end
                end else if (i - len_t'(7) > len_t'(USERID_LIMIT)) begin
                    too_long_next = 1'b1;
                end
            end else if (phase_next == PHASE_DOMAIN) begin
                if (b == 8'h00) begin
                    dom_end_next = i1;
                    phase_next = PHASE_DONE;
                end else if ({1'b0, i} + (LENGTH_BITS+1)'(1) - {1'b0, uid_end_next}
                             > (LENGTH_BITS+1)'(DOMAIN_LIMIT)) begin
                    too_long_next = 1'b1;
                end
            end
        end
        if (i == CNT_MAX) over_next = 1'b1;
        else cnt_next = i1;
    end

    // pdu length selection on the updated state
    always_comb begin
        len_t  len;
        len_t  msg;
        len_t  auth_neg, v4_reply, auth_reply, userpass, up_reply, v5_conn, v4_req;
        len_t  need, addr;
        logic  v5_ok;
        logic [3:0] st;
        byte_t m;
        len = cnt_next;
        st  = sess_next[3:0];
        m   = hdr_next[1];
        // socks5 method negotiation
        auth_neg = '0;
        need = len_t'(hdr_next[1]) + len_t'(2);
        if (len >= len_t'(2) && hdr_next[0] == 8'h05 && hdr_next[1] != 8'h00 && len >= need)
            auth_neg = need;
        v4_reply = (len >= len_t'(8) && hdr_next[0] == 8'h00) ? len_t'(8) : '0;
        // method reply, falls back to socks4 reply
        auth_reply = '0;
        if (len >= len_t'(2)) begin
            if (hdr_next[0] == 8'h05) begin
                if (m != 8'h00 && m != 8'h02 && m != 8'hFF) auth_reply = len;
                else auth_reply = len_t'(2);
            end else if (hdr_next[0] == 8'h00) begin
                auth_reply = v4_reply;
            end
        end
        // username/password request
        userpass = '0;
        if (len >= len_t'(3) && hdr_next[0] == 8'h01 &&
            {1'b0, len} >= (LENGTH_BITS+1)'(hdr_next[1]) + (LENGTH_BITS+1)'(3) &&
            len >= len_t'(up_end_next))
            userpass = len_t'(up_end_next);
        up_reply = (len >= len_t'(2) && hdr_next[0] == 8'h01) ? len_t'(2) : '0;
        // socks5 connect request or reply
        v5_conn = '0;
        v5_ok = 1'b1;
        addr = '0;
        case (hdr_next[3])
            8'h01: addr = len_t'(4);
            8'h03: begin
                if (len < len_t'(5) || hdr_next[4] == 8'h00 ||
                    hdr_next[4] > 8'(DOMAIN_LIMIT)) v5_ok = 1'b0;
                addr = len_t'(hdr_next[4]) + len_t'(1);
            end
            8'h04: addr = len_t'(16);
            default: v5_ok = 1'b0;
        endcase
        if (len < len_t'(4) || hdr_next[0] != 8'h05) v5_ok = 1'b0;
        if (v5_ok && len >= addr + len_t'(6)) v5_conn = addr + len_t'(6);
        // socks4 request with user id and optional domain
        v4_req = '0;
        if (len >= len_t'(9) && hdr_next[0] == 8'h04 && !too_long_next &&
            phase_next == PHASE_DONE)
            v4_req = dom_end_next;

        msg = '0;
        if (sess_next[4]) begin
            case (st)
                ST_INIT, ST_V5_NEG: begin
                    if (v4_req != '0) msg = v4_req;
                    else if (len >= len_t'(2) && hdr_next[0] == 8'h05) msg = auth_neg;
                end
                ST_USERPASS: msg = userpass;
                ST_V5_REQ, ST_BR_RESP: msg = v5_conn;
                ST_BR_NEG: msg = (auth_reply != '0) ? auth_reply : userpass;
                ST_BR_AUTH: begin
                    if (len >= len_t'(2) && hdr_next[0] == 8'h01) msg = userpass;
                    else msg = auth_neg;
                end
                ST_BR_REQ: begin
                    if (len >= len_t'(4) && hdr_next[0] == 8'h05 && hdr_next[2] == 8'h05)
                        msg = len_t'(2);
                    else if (len == len_t'(2) && auth_reply != '0) msg = auth_reply;
                    else msg = v5_conn;
                end
                default: msg = '0;
            endcase
        end else begin
            case (st)
                ST_INIT, ST_V5_NEG, ST_BR_NEG: msg = auth_reply;
                ST_V4_RESP: msg = v4_reply;
                ST_USERPASS: msg = up_reply;
                ST_V5_REQ, ST_V5_RESP, ST_BR_AUTH, ST_BR_REQ: msg = v5_conn;
                ST_BR_RESP: msg = len;
                default: msg = '0;
            endcase
        end

        verdict_next = VERDICT_SEARCH;
        flen_next = '0;
        if (st == ST_ESTAB || sess_next[5]) begin
            verdict_next = VERDICT_STOP;
        end else if (st == ST_ERROR) begin
            verdict_next = VERDICT_FLUSH;
            flen_next = len[15:0];
        end else if (msg != '0 && msg <= len) begin
            verdict_next = VERDICT_FLUSH;
            flen_next = msg[15:0];
        end
    end

    // state and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            for (int k = 0; k < 8; k++) hdr_reg[k] <= 8'h00;
            sess_reg <= '0;
            up_end_reg <= '0;
            phase_reg <= PHASE_USERID;
            uid_end_reg <= '0;
            dom_end_reg <= '0;
            too_long_reg <= 1'b0;
            over_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) m_valid_reg <= 1'b0;
            if (take) begin
                cnt_reg <= cnt_next;
                for (int k = 0; k < 8; k++) hdr_reg[k] <= hdr_next[k];
                sess_reg <= sess_next;
                up_end_reg <= up_end_next;
                phase_reg <= phase_next;
                uid_end_reg <= uid_end_next;
                dom_end_reg <= dom_end_next;
                too_long_reg <= too_long_next;
                over_reg <= over_next;
                if (s_buffer_end) m_valid_reg <= 1'b1;
            end
        end
    end

    // verdict payload
    always_ff @(posedge aclk) begin
        if (take && s_buffer_end) begin
            verdict_reg <= verdict_next;
            flen_reg <= flen_next;
            sat_reg <= over_next;
        end
    end
endmodule

@@ tb/sv/socks_message_boundary_finder_tb.sv @@
// testbench for the socks message boundary finder: directed and random buffers checked against a predictor
`timescale 1ns / 100ps
module socks_message_boundary_finder_tb;
    import smbf_pkg::*;

    // one byte of stream with its buffer markers and the phase it belongs to
    typedef struct packed {
        byte_t      data;
        logic       first;
        logic       last;
        logic       fc;
        logic [3:0] st;
        logic       ho;
        logic [1:0] ph;
    } scan_word_t;

    typedef struct packed {
        logic [1:0] verdict;
        len_t       flen;
        logic       sat;
    } verdict_word_t;

    // kinds of pdu the generator can build
    typedef enum int {
        K_AUTH_NEG, K_AUTH_REPLY, K_V4_REPLY, K_V4_REQ,
        K_USERPASS, K_UP_REPLY, K_V5_CONN, K_NOISE
    } pdu_kind_t;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_buffer_start = 1'b0;
    logic        s_buffer_end = 1'b0;
    logic        s_from_client = 1'b0;
    logic [3:0]  s_session_state = '0;
    logic        s_handoff_done = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_verdict;
    logic [15:0] m_flush_length;
    logic        m_length_saturated;

    scan_word_t    pending_words[$];
    verdict_word_t expected_verdicts[$];
    byte_t         pdu[$];
    logic [1:0]    cur_phase = 2'd0;
    bit            fill_done = 1'b0;
    int            errors = 0;
    int            n_buffers = 0;
    int            n_checked = 0;
    int            n_flush = 0;
    int            n_stop = 0;
    int            n_sat = 0;
    int            quiet_cycles = 0;

    // predictor state, matching the block after reset
    longint     seg_count = 0;
    byte_t      seg_head[8] = '{default: 8'h00};
    logic [3:0] lat_state = 4'd0;
    logic       lat_client = 1'b0;
    logic       lat_handoff = 1'b0;
    longint     up_end = 0;
    logic [1:0] id_phase = PHASE_USERID;
    longint     id_end = 0;
    longint     dom_end = 0;
    bit         too_long = 1'b0;
    bit         cnt_over = 1'b0;

    socks_message_boundary_finder DUT (.*);

    always #4 aclk = ~aclk;

    // pdu length functions, 0 when no complete pdu
    function automatic longint auth_neg_len(longint len);
        longint need;
        if (len < 2 || seg_head[0] != 8'h05 || seg_head[1] == 0) return 0;
        need = 2 + seg_head[1];
        return len >= need ? need : 0;
    endfunction

    function automatic longint v4_reply_len(longint len);
        return (len >= 8 && seg_head[0] == 8'h00) ? 8 : 0;
    endfunction

    function automatic longint auth_reply_len(longint len);
        if (len < 2) return 0;
        if (seg_head[0] == 8'h05) begin
            if (seg_head[1] != 8'h00 && seg_head[1] != 8'h02 && seg_head[1] != 8'hFF)
                return len;
            return 2;
        end
        if (seg_head[0] == 8'h00) return v4_reply_len(len);
        return 0;
    endfunction

    function automatic longint userpass_len(longint len);
        if (len < 3 || seg_head[0] != 8'h01) return 0;
        if (len < 3 + longint'(seg_head[1])) return 0;
        return len >= up_end ? up_end : 0;
    endfunction

    function automatic longint v5_conn_len(longint len);
        longint addr;
        if (len < 4 || seg_head[0] != 8'h05) return 0;
        case (seg_head[3])
            8'h01: addr = 4;
            8'h03: begin
                if (len < 5) return 0;
                if (seg_head[4] == 0 || seg_head[4] > DOMAIN_LIMIT) return 0;
                addr = 1 + seg_head[4];
            end
            8'h04: addr = 16;
            default: return 0;
        endcase
        return len >= 6 + addr ? 6 + addr : 0;
    endfunction

    function automatic longint v4_req_len(longint len);
        if (len < 9 || seg_head[0] != 8'h04) return 0;
        if (too_long || id_phase != PHASE_DONE) return 0;
        return dom_end;
    endfunction

    function automatic longint client_len(logic [3:0] st, longint len);
        longint r;
        case (st)
            ST_INIT, ST_V5_NEG: begin
                if (len >= 9 && seg_head[0] == 8'h04) begin
                    r = v4_req_len(len);
                    if (r != 0) return r;
                end
                if (len >= 2 && seg_head[0] == 8'h05) return auth_neg_len(len);
                return 0;
            end
            ST_USERPASS: return userpass_len(len);
            ST_V5_REQ:   return v5_conn_len(len);
            ST_BR_NEG: begin
                r = auth_reply_len(len);
                return r != 0 ? r : userpass_len(len);
            end
            ST_BR_AUTH: begin
                if (len >= 2 && seg_head[0] == 8'h01) return userpass_len(len);
                return auth_neg_len(len);
            end
            ST_BR_REQ: begin
                if (len >= 4 && seg_head[0] == 8'h05 && seg_head[2] == 8'h05) return 2;
                if (len == 2) begin
                    r = auth_reply_len(len);
                    if (r != 0) return r;
                end
                return v5_conn_len(len);
            end
            ST_BR_RESP: return v5_conn_len(len);
            default: return 0;
        endcase
    endfunction

    function automatic longint server_len(logic [3:0] st, longint len);
        case (st)
            ST_INIT, ST_V5_NEG, ST_BR_NEG: return auth_reply_len(len);
            ST_V4_RESP:  return v4_reply_len(len);
            ST_USERPASS: return (len >= 2 && seg_head[0] == 8'h01) ? 2 : 0;
            ST_V5_REQ, ST_V5_RESP, ST_BR_AUTH, ST_BR_REQ: return v5_conn_len(len);
            ST_BR_RESP:  return len;
            default: return 0;
        endcase
    endfunction

    // advance the scan with one accepted word, queue a verdict on the last word
    task automatic scan_word(input scan_word_t w);
        longint i;
        longint msg;
        verdict_word_t v;
        if (w.first) begin
            seg_count = 0;
            foreach (seg_head[k]) seg_head[k] = '0;
            up_end = 0;
            id_phase = PHASE_USERID;
            id_end = 0;
            dom_end = 0;
            too_long = 0;
            cnt_over = 0;
            lat_state = w.st;
            lat_client = w.fc;
            lat_handoff = w.ho;
        end
        i = seg_count;
        if (i < 8) seg_head[i] = w.data;
        if (i >= 2 && i == 2 + longint'(seg_head[1])) up_end = 3 + seg_head[1] + w.data;
        if (i >= 8 && !too_long) begin
            if (id_phase == PHASE_USERID) begin
                if (w.data == 0) begin
                    id_end = i + 1;
                    if (seg_head[4] == 0 && seg_head[5] == 0 && seg_head[6] == 0 &&
                        seg_head[7] != 0) begin
                        id_phase = PHASE_DOMAIN;
                    end else begin
                        dom_end = id_end;
                        id_phase = PHASE_DONE;
                    end
                end else if (i + 1 - 8 > USERID_LIMIT) begin
                    too_long = 1;
                end
            end else if (id_phase == PHASE_DOMAIN) begin
                if (w.data == 0) begin
                    dom_end = i + 1;
                    id_phase = PHASE_DONE;
                end else if (i + 1 - id_end > DOMAIN_LIMIT) begin
                    too_long = 1;
                end
            end
        end
        if (seg_count >= 65535) cnt_over = 1;
        else seg_count++;
        if (!w.last) return;
        v = '0;
        if (lat_state == ST_ESTAB || lat_handoff) begin
            v.verdict = VERDICT_STOP;
        end else if (lat_state == ST_ERROR) begin
            v.verdict = VERDICT_FLUSH;
            v.flen = len_t'(seg_count);
        end else begin
            msg = lat_client ? client_len(lat_state, seg_count)
                             : server_len(lat_state, seg_count);
            if (msg > 0 && msg <= seg_count) begin
                v.verdict = VERDICT_FLUSH;
                v.flen = len_t'(msg);
            end
        end
        v.sat = cnt_over;
        expected_verdicts.push_back(v);
    endtask

    // queue the bytes in pdu as one buffer
    task automatic push_buffer(logic [3:0] st, logic fc, logic ho, logic [1:0] ph,
                               bit with_start = 1, bit with_end = 1);
        scan_word_t w;
        foreach (pdu[k]) begin
            w.data = pdu[k];
            w.first = with_start && k == 0;
            w.last = with_end && k == pdu.size() - 1;
            w.fc = fc;
            w.st = st;
            w.ho = ho;
            w.ph = ph;
            pending_words.push_back(w);
        end
        pdu.delete();
    endtask

    task automatic build_pdu(pdu_kind_t kind);
        int n;
        int m;
        case (kind)
            K_AUTH_NEG: begin
                n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
                pdu = '{8'h05, byte_t'(n)};
                repeat (n) pdu.push_back(byte_t'($urandom));
            end
            K_AUTH_REPLY: begin
                m = $urandom_range(3);
                pdu = '{8'h05, (m == 0) ? 8'h00 : (m == 1) ? 8'h02 :
                        (m == 2) ? 8'hFF : byte_t'($urandom)};
            end
            K_V4_REPLY: begin
                pdu = '{8'h00, 8'h5A};
                repeat (6) pdu.push_back(byte_t'($urandom));
            end
            K_V4_REQ: begin
                pdu = '{8'h04, 8'h01, byte_t'($urandom), byte_t'($urandom)};
                m = $urandom_range(1);
                if (m) pdu = {pdu, 8'h00, 8'h00, 8'h00, byte_t'($urandom_range(1, 255))};
                else repeat (4) pdu.push_back(byte_t'($urandom));
                n = ($urandom_range(19) == 0) ? $urandom_range(250, 262) : $urandom_range(12);
                repeat (n) pdu.push_back(byte_t'($urandom_range(1, 255)));
                pdu.push_back(8'h00);
                if (m) begin
                    n = ($urandom_range(19) == 0) ? $urandom_range(250, 258) : $urandom_range(16);
                    repeat (n) pdu.push_back(byte_t'($urandom_range(1, 255)));
                    pdu.push_back(8'h00);
                end
            end
            K_USERPASS: begin
                n = $urandom_range(10);
                pdu = '{8'h01, byte_t'(n)};
                repeat (n) pdu.push_back(byte_t'($urandom));
                n = $urandom_range(10);
                pdu.push_back(byte_t'(n));
                repeat (n) pdu.push_back(byte_t'($urandom));
            end
            K_UP_REPLY: pdu = '{8'h01, byte_t'($urandom_range(1))};
            K_V5_CONN: begin
                m = $urandom_range(5);
                pdu = '{8'h05, byte_t'($urandom_range(1, 3)), 8'h00,
                        (m < 2) ? 8'h01 : (m < 4) ? 8'h03 : (m == 4) ? 8'h04
                                 : byte_t'($urandom)};
                n = (pdu[3] == 8'h01) ? 4 : (pdu[3] == 8'h04) ? 16 : 0;
                if (pdu[3] == 8'h03) begin
                    n = $urandom_range(7) == 0 ? $urandom_range(252, 255) * $urandom_range(1)
                                              : $urandom_range(1, 20);
                    pdu.push_back(byte_t'(n));
                end
                repeat (n + 2) pdu.push_back(byte_t'($urandom));
            end
            default: begin
                n = $urandom_range(1, 12);
                repeat (n) pdu.push_back(byte_t'($urandom));
            end
        endcase
    endtask

    // pick a session that suits the pdu most of the time
    task automatic add_random_buffer(logic [1:0] ph);
        pdu_kind_t kind;
        logic [3:0] st;
        logic fc;
        int r;
        int cut;
        kind = pdu_kind_t'($urandom_range(K_NOISE));
        build_pdu(kind);
        r = $urandom_range(3);
        case (kind)
            K_AUTH_NEG: begin
                fc = 1'b1;
                st = r == 0 ? ST_INIT : r == 1 ? ST_V5_NEG : ST_BR_AUTH;
            end
            K_AUTH_REPLY: begin
                fc = r[0];
                st = fc ? (r[1] ? ST_BR_NEG : ST_BR_REQ) : (r[1] ? ST_V5_NEG : ST_BR_NEG);
            end
            K_V4_REPLY: begin fc = 1'b0; st = r[0] ? ST_V4_RESP : ST_INIT; end
            K_V4_REQ: begin fc = 1'b1; st = r[0] ? ST_INIT : ST_V5_NEG; end
            K_USERPASS: begin
                fc = 1'b1;
                st = r == 0 ? ST_BR_NEG : r == 1 ? ST_BR_AUTH : ST_USERPASS;
            end
            K_UP_REPLY: begin fc = 1'b0; st = ST_USERPASS; end
            K_V5_CONN: begin
                fc = r[0];
                st = fc ? (r[1] ? ST_V5_REQ : ST_BR_REQ) : (r[1] ? ST_V5_RESP : ST_BR_AUTH);
            end
            default: begin fc = 1'($urandom_range(1)); st = 4'($urandom_range(15)); end
        endcase
        if ($urandom_range(9) < 3) begin
            fc = 1'($urandom_range(1));
            st = 4'($urandom_range(15));
        end
        // truncate, extend or corrupt some of them
        r = $urandom_range(9);
        if (r == 0 && pdu.size() > 1) begin
            cut = $urandom_range(1, pdu.size() - 1);
            pdu = pdu[0:cut-1];
        end else if (r == 1) begin
            repeat ($urandom_range(1, 6)) pdu.push_back(byte_t'($urandom));
        end else if (r == 2) begin
            pdu[$urandom_range(pdu.size() - 1)] = byte_t'($urandom);
        end
        push_buffer(st, fc, $urandom_range(9) == 0, ph, 1, $urandom_range(19) != 0);
        // occasional trailing bytes with no buffer start
        if ($urandom_range(24) == 0) begin
            repeat ($urandom_range(1, 3)) pdu.push_back(byte_t'($urandom));
            push_buffer(4'($urandom), 1'($urandom_range(1)), 1'b0, ph, 0, 1);
        end
    endtask

    // stimulus
    initial begin
        // bytes before any buffer start use the reset session
        pdu = '{8'h05, 8'h02};
        push_buffer(ST_INIT, 1'b0, 1'b0, 2'd0, 0, 1);
        pdu = '{8'hFF, 8'h00, 8'h80};
        push_buffer(ST_ESTAB, 1'b1, 1'b0, 2'd0);
        pdu = '{8'h00, 8'hFF};
        push_buffer(ST_ERROR, 1'b0, 1'b0, 2'd0);
        pdu = '{8'h05, 8'h01, 8'h00};
        push_buffer(ST_V5_NEG, 1'b1, 1'b1, 2'd0);
        pdu = '{8'h05, 8'h07, 8'h55};
        push_buffer(ST_V5_NEG, 1'b0, 1'b0, 2'd0);
        pdu = '{8'h12, 8'h34};
        push_buffer(ST_BR_RESP, 1'b0, 1'b0, 2'd0);
        pdu = '{8'h05, 8'h01};
        push_buffer(4'd15, 1'b1, 1'b0, 2'd0);
        pdu = '{8'h05, 8'h01, 8'h00, 8'h03, 8'h00, 8'h01};
        push_buffer(ST_V5_REQ, 1'b1, 1'b0, 2'd0);
        pdu = '{8'h05, 8'h01, 8'h05, 8'h01};
        push_buffer(ST_BR_REQ, 1'b1, 1'b0, 2'd0);
        n_buffers = 9;
        for (int k = 0; k < 1950 && pending_words.size() < 1950; k++) begin
            add_random_buffer(pending_words.size() < 650 ? 2'd0 :
                              pending_words.size() < 1300 ? 2'd1 : 2'd2);
            n_buffers++;
        end
        // close with a complete buffer so no buffer is left open
        pdu = '{8'h05, 8'h00};
        push_buffer(ST_INIT, 1'b0, 1'b0, 2'd2);
        n_buffers += 1;
        fill_done = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_words.size() != 0 || s_valid || expected_verdicts.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("covered %0d buffers, %0d verdicts checked (%0d flush, %0d stop, %0d saturated)",
                 n_buffers, n_checked, n_flush, n_stop, n_sat);
        if (errors == 0 && expected_verdicts.size() == 0 && !m_valid) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // driver: feed words, run the predictor on each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                scan_word({s_data_byte, s_buffer_start, s_buffer_end, s_from_client,
                           s_session_state, s_handoff_done, cur_phase});
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && fill_done &&
                    $urandom_range(99) >= (pending_words[0].ph == 0 ? 8 :
                                           pending_words[0].ph == 1 ? 52 : 0)) begin
                    scan_word_t w;
                    w = pending_words.pop_front();
                    cur_phase <= w.ph;
                    s_valid <= 1'b1;
                    s_data_byte <= w.data;
                    s_buffer_start <= w.first;
                    s_buffer_end <= w.last;
                    s_from_client <= w.fc;
                    s_session_state <= w.st;
                    s_handoff_done <= w.ho;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back pressure and compare against the oldest verdict
    always @(posedge aclk) begin
        m_ready <= $urandom_range(99) >= (cur_phase == 0 ? 52 : cur_phase == 1 ? 8 : 0);
        if (aresetn && m_valid && m_ready) begin
            if (expected_verdicts.size() == 0) begin
                $error("verdict word with none expected");
                errors++;
            end else begin
                verdict_word_t e;
                e = expected_verdicts.pop_front();
                n_checked++;
                if (e.verdict == VERDICT_FLUSH) n_flush++;
                if (e.verdict == VERDICT_STOP) n_stop++;
                if (e.sat) n_sat++;
                if (m_verdict !== e.verdict) begin
                    $error("verdict: expected %0d got %0d", e.verdict, m_verdict);
                    errors++;
                end
                if (m_flush_length !== e.flen) begin
                    $error("flush_length: expected %0d got %0d", e.flen, m_flush_length);
                    errors++;
                end
                if (m_length_saturated !== e.sat) begin
                    $error("length_saturated: expected %0d got %0d", e.sat,
                           m_length_saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end
endmodule
